/* rtl/fpcs_pkg.sv */
package fpcs_pkg;

   localparam logic [7:0] START_MARKER_RESET = 8'hAA;
   localparam int         QUEUE_DEPTH        = 2;

   typedef enum logic [2:0] {
      VERDICT_OK       = 3'd0,
      VERDICT_SHORT    = 3'd1,
      VERDICT_START    = 3'd2,
      VERDICT_LENGTH   = 3'd3,
      VERDICT_CHECKSUM = 3'd4
   } verdict_type;

   localparam logic KIND_PAYLOAD = 1'b0;
   localparam logic KIND_VERDICT = 1'b1;

   typedef struct packed {
      logic [7:0] rx_byte;
      logic       end_of_buffer;
   } req_type;

   typedef struct packed {
      logic       result_kind;
      logic [7:0] payload_byte;
      logic [2:0] verdict;
      logic [7:0] frame_length;
   } rsp_type;

endpackage

/* rtl/framed_packet_checksum_parser.sv */
// A result is queued as its byte is taken; it can show on rsp_ from the cycle after.
// Throughput: one byte per cycle while req_stall is low; a small result queue
// (QueueDepth entries) decouples the parser from the output side.
// req_stall rises only when the result queue is full.
// Reset (synchronous) returns the parser to waiting for a first byte, empties the
// queue and sets start_marker back to 0xAA.
module framed_packet_checksum_parser
   import fpcs_pkg::*;
#(
   parameter int QueueDepth = QUEUE_DEPTH
)
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  req_type    req_data,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output rsp_type    rsp_data,
   input  logic       csr_valid,
   output logic       csr_ready,
   input  logic [7:0] csr_data
);

   logic [7:0] marker_ff;
   logic       in_fire;
   logic       push;
   logic       full;
   rsp_type    push_data;

   assign csr_ready = 1'b1;
   assign req_stall = full;
   assign in_fire   = req_valid && !req_stall;

   always_ff @(posedge clock) begin
      if (reset)
         marker_ff <= START_MARKER_RESET;
      else if (csr_valid && csr_ready)
         marker_ff <= csr_data;
   end

   fpcs_front u_front (
      .clock     (clock),
      .reset     (reset),
      .marker    (marker_ff),
      .in_fire   (in_fire),
      .in_data   (req_data),
      .push      (push),
      .push_data (push_data)
   );

   fpcs_queue #(
      .Depth (QueueDepth)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .full      (full),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

endmodule

/* rtl/fpcs_front.sv */
module fpcs_front
   import fpcs_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic [7:0] marker,
   input  logic       in_fire,
   input  req_type    in_data,
   output logic       push,
   output rsp_type    push_data
);

   typedef enum logic [1:0] {
      PH_FIRST,
      PH_LENGTH,
      PH_BODY,
      PH_IGNORE
   } phase_type;

   phase_type  phase_ff, phase_in;
   logic [7:0] sum_ff, sum_in;
   logic [7:0] len_ff, len_in;
   logic [7:0] left_ff, left_in;
   logic       bad_ff, bad_in;

   logic [7:0] b;
   logic       eob;

   assign b   = in_data.rx_byte;
   assign eob = in_data.end_of_buffer;

   function automatic rsp_type make_verdict(verdict_type v, logic [7:0] len);
      rsp_type r;
      r.result_kind  = KIND_VERDICT;
      r.payload_byte = 8'd0;
      r.verdict      = v;
      r.frame_length = len;
      return r;
   endfunction

   always_comb begin
      phase_in  = phase_ff;
      sum_in    = sum_ff;
      len_in    = len_ff;
      left_in   = left_ff;
      bad_in    = bad_ff;
      push      = 1'b0;
      push_data = '0;
      if (in_fire) begin
         unique case (phase_ff)
            PH_FIRST: begin
               bad_in  = (b != marker);
               sum_in  = b;
               len_in  = 8'd0;
               left_in = 8'd0;
               if (eob) begin
                  push      = 1'b1;
                  push_data = make_verdict(VERDICT_SHORT, 8'd0);
               end else begin
                  phase_in = PH_LENGTH;
               end
            end
            PH_LENGTH: begin
               if (eob) begin
                  phase_in  = PH_FIRST;
                  push      = 1'b1;
                  push_data = make_verdict(VERDICT_SHORT, 8'd0);
               end else begin
                  len_in   = b;
                  left_in  = b;
                  sum_in   = sum_ff + b;
                  phase_in = PH_BODY;
               end
            end
            PH_BODY: begin
               priority if (bad_ff) begin
                  phase_in  = eob ? PH_FIRST : PH_IGNORE;
                  push      = 1'b1;
                  push_data = make_verdict(VERDICT_START, 8'd0);
               end else if (left_ff != 8'd0) begin
                  push = 1'b1;
                  if (eob) begin
                     phase_in  = PH_FIRST;
                     push_data = make_verdict(VERDICT_LENGTH, 8'd0);
                  end else begin
                     sum_in                 = sum_ff + b;
                     left_in                = left_ff - 8'd1;
                     push_data.result_kind  = KIND_PAYLOAD;
                     push_data.payload_byte = b;
                  end
               end else begin
                  // checksum byte
                  phase_in = eob ? PH_FIRST : PH_IGNORE;
                  push     = 1'b1;
                  if (b == sum_ff)
                     push_data = make_verdict(VERDICT_OK, len_ff);
                  else
                     push_data = make_verdict(VERDICT_CHECKSUM, 8'd0);
               end
            end
            PH_IGNORE: begin
               if (eob)
                  phase_in = PH_FIRST;
            end
            default: phase_in = PH_FIRST;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_FIRST;
         sum_ff   <= 8'd0;
         len_ff   <= 8'd0;
         left_ff  <= 8'd0;
         bad_ff   <= 1'b0;
      end else begin
         phase_ff <= phase_in;
         sum_ff   <= sum_in;
         len_ff   <= len_in;
         left_ff  <= left_in;
         bad_ff   <= bad_in;
      end
   end

endmodule

/* rtl/fpcs_queue.sv */
module fpcs_queue
   import fpcs_pkg::*;
#(
   parameter int Depth = QUEUE_DEPTH
)
(
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  rsp_type push_data,
   output logic    full,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_data
);

   localparam int IdxW = (Depth > 1) ? $clog2(Depth) : 1;
   localparam int CntW = $clog2(Depth + 1);

   rsp_type         mem [Depth];
   logic [IdxW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [IdxW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CntW-1:0] count_ff, count_in;
   logic            pop;

   assign full      = (count_ff == CntW'(Depth));
   assign rsp_valid = (count_ff != '0);
   assign rsp_data  = mem[rd_ptr_ff];
   assign pop       = rsp_valid && !rsp_stall;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push)
         wr_ptr_in = (wr_ptr_ff == IdxW'(Depth - 1)) ? '0 : wr_ptr_ff + 1'b1;
      if (pop)
         rd_ptr_in = (rd_ptr_ff == IdxW'(Depth - 1)) ? '0 : rd_ptr_ff + 1'b1;
      if (push && !pop)
         count_in = count_ff + 1'b1;
      else if (pop && !push)
         count_in = count_ff - 1'b1;
   end

   always_ff @(posedge clock) begin
      if (push)
         mem[wr_ptr_ff] <= push_data;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule
